@@ design/assert_macros.svh @@
// Assertion macros for the motion fuzz / deadzone filter.
// Used by files that hold concurrent assertions; they need signals clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define MFDZ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true on a rising clk edge out of reset.
`define MFDZ_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) not (cond)) else $error(msg);

`endif

@@ design/mfdz_pkg.sv @@
// Shared widths, register indexes, reset values and types of the motion filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfdz_pkg;

	localparam int RAW_W        = 16;
	localparam int OUT_W        = 25;
	localparam int FUZZ_W       = 15;
	localparam int WEIGHT_W     = 9;
	localparam int WEIGHT_SH    = 8;
	localparam int FRAC_BITS_DEF = 8;

	localparam int NUM_ACCEL  = 3;
	localparam int NUM_ORIENT = 4;
	localparam int NUM_GYRO   = 3;
	localparam int NUM_FUZZ   = NUM_ACCEL + NUM_ORIENT;
	localparam int NCH        = NUM_FUZZ + NUM_GYRO;

	// Channels sent out negated
	localparam int CH_ACCEL_Z  = 2;
	localparam int CH_ORIENT_Z = 6;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = FUZZ_W;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FUZZ    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENT_FUZZ   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_DEADZONE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEAR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FAR    = 3'd4;

	localparam logic [FUZZ_W-1:0]   ACCEL_FUZZ_RST    = 15'd256;
	localparam logic [FUZZ_W-1:0]   ORIENT_FUZZ_RST   = 15'd24;
	localparam logic [FUZZ_W-1:0]   GYRO_DEADZONE_RST = 15'd24;
	localparam logic [WEIGHT_W-1:0] WEIGHT_NEAR_RST   = 9'd192;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FAR_RST    = 9'd154;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE        = 9'd256;

	typedef struct packed {
		logic [FUZZ_W-1:0]   fuzz;
		logic [WEIGHT_W-1:0] weight_near;
		logic [WEIGHT_W-1:0] weight_far;
	} fuzz_cfg_t;

endpackage

`default_nettype wire

@@ design/mfdz_fuzz.sv @@
// One fuzz-filtered channel: kept value register plus hold / blend / take logic.
// Depends on mfdz_pkg.
`default_nettype none

module mfdz_fuzz #(
	parameter int FRAC_BITS = mfdz_pkg::FRAC_BITS_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         upd,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0]     raw,
	input  wire  mfdz_pkg::fuzz_cfg_t                   cfg,
	output logic signed [mfdz_pkg::RAW_W+FRAC_BITS-1:0] nxt,
	output logic                                        chg
);
	import mfdz_pkg::*;

	localparam int KW = RAW_W + FRAC_BITS;
	localparam int DW = KW + 1;
	localparam int PW = DW + WEIGHT_W + 1;

	logic signed [KW-1:0]       kept_q;
	logic signed [KW-1:0]       cur;
	logic signed [DW-1:0]       diff;
	logic        [DW-1:0]       mag;
	logic        [DW-1:0]       th_half, th_one, th_two;
	logic                       in_hold, in_near, in_far;
	logic        [WEIGHT_W-1:0] w_sel, w_sat;
	logic signed [PW-1:0]       prod, corr, sum;
	logic signed [KW-1:0]       blended;

	assign cur  = KW'(raw) <<< FRAC_BITS;
	assign diff = DW'(cur) - DW'(kept_q);
	// magnitude; the most negative difference maps onto 2^KW as unsigned
	assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

	assign th_half = DW'(cfg.fuzz) << (FRAC_BITS - 1);
	assign th_one  = DW'(cfg.fuzz) << FRAC_BITS;
	assign th_two  = DW'(cfg.fuzz) << (FRAC_BITS + 1);

	assign in_hold = mag < th_half;
	assign in_near = mag < th_one;
	assign in_far  = mag < th_two;

	assign w_sel = in_near ? cfg.weight_near : cfg.weight_far;
	assign w_sat = (w_sel > WEIGHT_ONE) ? WEIGHT_ONE : w_sel;

	// (w*p + (1-w)*c) floored == c + floor(-w*(c-p))
	assign prod    = PW'(signed'({1'b0, w_sat})) * PW'(diff);
	assign corr    = (-prod) >>> WEIGHT_SH;
	assign sum     = PW'(cur) + corr;
	assign blended = sum[KW-1:0];

	always_comb begin
		if (in_hold) begin
			nxt = kept_q;
		end else if (in_far) begin
			nxt = blended;
		end else begin
			nxt = cur;
		end
	end

	assign chg = !in_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (upd) begin
			kept_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ design/mfdz_dzone.sv @@
// One gyro channel: graded deadzone and kept value register.
// Depends on mfdz_pkg.
`default_nettype none

module mfdz_dzone #(
	parameter int FRAC_BITS = mfdz_pkg::FRAC_BITS_DEF
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         upd,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0]     raw,
	input  wire  logic [mfdz_pkg::FUZZ_W-1:0]           zone,
	output logic signed [mfdz_pkg::RAW_W+FRAC_BITS-1:0] nxt,
	output logic                                        chg
);
	import mfdz_pkg::*;

	localparam int KW = RAW_W + FRAC_BITS;
	localparam int MW = RAW_W + 1;

	logic signed [KW-1:0] kept_q;
	logic signed [MW-1:0] raw_x;
	logic        [MW-1:0] mag;
	logic        [MW-1:0] th1, th2, th4;

	assign raw_x = MW'(raw);
	assign mag   = raw_x[MW-1] ? MW'(-raw_x) : MW'(raw_x);
	assign th1   = MW'(zone);
	assign th2   = MW'(zone) << 1;
	assign th4   = MW'(zone) << 2;

	// quarter and half of the fixed-point sample are exact shifts
	always_comb begin
		if (mag < th1) begin
			nxt = '0;
		end else if (mag < th2) begin
			nxt = KW'(raw) <<< (FRAC_BITS - 2);
		end else if (mag < th4) begin
			nxt = KW'(raw) <<< (FRAC_BITS - 1);
		end else begin
			nxt = KW'(raw) <<< FRAC_BITS;
		end
	end

	assign chg = (nxt != kept_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (upd) begin
			kept_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ design/motion_fuzz_deadzone_filter.sv @@
// Top level of the motion fuzz / deadzone filter: registers, input stage, result stage.
// Depends on mfdz_pkg, mfdz_fuzz, mfdz_dzone and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid / in_ready): one motion report per request, ten raw signed
//    16-bit samples (3 accel, 4 orientation quaternion, 3 gyro).
//  - Output channel (out_valid / out_ready): one request per report in which a fuzz channel
//    left its hold band or a gyro kept value changed; it carries all ten kept values in
//    signed fixed point, accel z and orient z negated. Other reports give no output request.
//  - Config channel (cfg_valid / cfg_ready): index and data of one register; always ready.
//    Write only while the block is idle. Indexes beyond the register list are dropped.
//  - A report accepted into the input stage is filtered there and its result registered
//    in the result stage. Throughput: one report per cycle while out_ready keeps up; each
//    channel's kept register updates as its filter runs, so a new report can follow at once.
//  - Stall: while a result waits on out_ready, one more report is taken into the input
//    stage; after that in_ready drops until the result is taken.
//  - Reset (arst_n low, asynchronous): kept values clear to zero, registers return to their
//    defaults, both stages empty.
`default_nettype none
`include "assert_macros.svh"

module motion_fuzz_deadzone_filter #(
	parameter int FRAC_BITS = mfdz_pkg::FRAC_BITS_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,

	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire  logic [mfdz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  logic [mfdz_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  wire                                     in_valid,
	output logic                                    in_ready,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] accel_x_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] accel_y_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] accel_z_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] quat_w_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] quat_x_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] quat_y_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] quat_z_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] gyro_x_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] gyro_y_in,
	input  wire  logic signed [mfdz_pkg::RAW_W-1:0] gyro_z_in,

	output logic                                    out_valid,
	input  wire                                     out_ready,
	output logic signed [mfdz_pkg::OUT_W-1:0]       accel_x_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       accel_y_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       accel_z_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       quat_w_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       quat_x_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       quat_y_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       quat_z_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       gyro_x_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       gyro_y_out,
	output logic signed [mfdz_pkg::OUT_W-1:0]       gyro_z_out
);
	import mfdz_pkg::*;

	localparam int KW = RAW_W + FRAC_BITS;
	// sign-extended width wide enough for negation and for the output field
	localparam int EW = (KW + 1 > OUT_W) ? KW + 1 : OUT_W;

	// ---------------- configuration registers ----------------
	logic [FUZZ_W-1:0]   accel_fuzz_q, orient_fuzz_q, gyro_deadzone_q;
	logic [WEIGHT_W-1:0] weight_near_q, weight_far_q;
	fuzz_cfg_t           accel_cfg, orient_cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_fuzz_q    <= ACCEL_FUZZ_RST;
			orient_fuzz_q   <= ORIENT_FUZZ_RST;
			gyro_deadzone_q <= GYRO_DEADZONE_RST;
			weight_near_q   <= WEIGHT_NEAR_RST;
			weight_far_q    <= WEIGHT_FAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACCEL_FUZZ:    accel_fuzz_q    <= cfg_data;
				REG_ORIENT_FUZZ:   orient_fuzz_q   <= cfg_data;
				REG_GYRO_DEADZONE: gyro_deadzone_q <= cfg_data;
				REG_WEIGHT_NEAR:   weight_near_q   <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_FAR:    weight_far_q    <= cfg_data[WEIGHT_W-1:0];
				default: ;	// unknown index: write dropped
			endcase
		end
	end

	assign accel_cfg  = '{fuzz: accel_fuzz_q, weight_near: weight_near_q,
		weight_far: weight_far_q};
	assign orient_cfg = '{fuzz: orient_fuzz_q, weight_near: weight_near_q,
		weight_far: weight_far_q};

	// ---------------- handshake ----------------
	logic valid_s1;
	logic res_valid_s2;
	logic adv;	// stage 1 item moves on (filters run, kept values update)
	logic s1_blocked;	// stage 1 full behind a result the receiver has not taken

	assign adv        = valid_s1 && (!res_valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || adv;
	assign s1_blocked = valid_s1 && res_valid_s2 && !out_ready;

	// ---------------- input stage ----------------
	logic signed [RAW_W-1:0] raw_in [NCH];
	logic signed [RAW_W-1:0] raw_s1 [NCH];

	assign raw_in[0] = accel_x_in;
	assign raw_in[1] = accel_y_in;
	assign raw_in[2] = accel_z_in;
	assign raw_in[3] = quat_w_in;
	assign raw_in[4] = quat_x_in;
	assign raw_in[5] = quat_y_in;
	assign raw_in[6] = quat_z_in;
	assign raw_in[7] = gyro_x_in;
	assign raw_in[8] = gyro_y_in;
	assign raw_in[9] = gyro_z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int i = 0; i < NCH; i++) begin
				raw_s1[i] <= raw_in[i];
			end
		end
	end

	// ---------------- channel filters ----------------
	logic signed [KW-1:0] nxt [NCH];
	logic [NCH-1:0]       chg;

	for (genvar i = 0; i < NUM_FUZZ; i++) begin : g_fuzz
		mfdz_fuzz #(.FRAC_BITS(FRAC_BITS)) u_fuzz (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (adv),
			.raw    (raw_s1[i]),
			.cfg    ((i < NUM_ACCEL) ? accel_cfg : orient_cfg),
			.nxt    (nxt[i]),
			.chg    (chg[i])
		);
	end

	for (genvar i = NUM_FUZZ; i < NCH; i++) begin : g_gyro
		mfdz_dzone #(.FRAC_BITS(FRAC_BITS)) u_dzone (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (adv),
			.raw    (raw_s1[i]),
			.zone   (gyro_deadzone_q),
			.nxt    (nxt[i]),
			.chg    (chg[i])
		);
	end

	// ---------------- result stage ----------------
	logic signed [OUT_W-1:0] res_val [NCH];
	logic signed [OUT_W-1:0] res_s2  [NCH];

	for (genvar i = 0; i < NCH; i++) begin : g_res
		logic signed [EW-1:0] ext;
		logic signed [EW-1:0] sel;

		assign ext        = EW'(nxt[i]);
		assign sel        = (i == CH_ACCEL_Z || i == CH_ORIENT_Z) ? -ext : ext;
		assign res_val[i] = sel[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= |chg;
		end else if (out_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (|chg)) begin
			for (int i = 0; i < NCH; i++) begin
				res_s2[i] <= res_val[i];
			end
		end
	end

	assign out_valid    = res_valid_s2;
	assign accel_x_out  = res_s2[0];
	assign accel_y_out  = res_s2[1];
	assign accel_z_out  = res_s2[2];
	assign quat_w_out   = res_s2[3];
	assign quat_x_out   = res_s2[4];
	assign quat_y_out   = res_s2[5];
	assign quat_z_out   = res_s2[6];
	assign gyro_x_out   = res_s2[7];
	assign gyro_y_out   = res_s2[8];
	assign gyro_z_out   = res_s2[9];

	// ---------------- assertions ----------------
	`MFDZ_ASSERT(a_stall_only_when_full, !in_ready |-> s1_blocked, "input stalled with room")
	`MFDZ_ASSERT(a_result_from_stage1, $rose(res_valid_s2) |-> $past(valid_s1), "orphan result")
	`MFDZ_ASSERT(a_stage1_held, (valid_s1 && !adv) |=> valid_s1, "stage 1 request lost")
	`MFDZ_NEVER(a_no_update_on_stall, adv && s1_blocked, "advanced over a waiting result")

endmodule

`default_nettype wire
